// File: sv/mcbp_pkg.sv
// Package for the multi-channel byte pipe FIFO.
// Holds the request and result field types and the operation and status codes.
// Depends on nothing.
package mcbp_pkg;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_pipe_id;
    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_status;
    typedef logic [6:0] t_fill;
    typedef logic [6:0] t_capacity;

    localparam t_func FUNC_WRITE = 2'd0;
    localparam t_func FUNC_READ  = 2'd1;
    localparam t_func FUNC_END   = 2'd2;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BAD_PIPE = 3'd1;
    localparam t_status ST_WR_CLOSED = 3'd2;
    localparam t_status ST_EOS      = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;
    localparam t_status ST_FULL     = 3'd5;

    localparam t_capacity CAPACITY_RESET = 7'd64;

endpackage

// File: sv/mcbp_req_if.sv
// Request channel of the multi-channel byte pipe FIFO.
// Carries valid, ready and one request; depends on mcbp_pkg.
interface mcbp_req_if;
    import mcbp_pkg::*;

    logic     valid;
    logic     ready;
    t_func    func;
    t_pipe_id pipe_id;
    t_byte    write_byte;

    modport source (output valid, func, pipe_id, write_byte, input ready);
    modport sink   (input valid, func, pipe_id, write_byte, output ready);
endinterface

// File: sv/mcbp_rsp_if.sv
// Result channel of the multi-channel byte pipe FIFO.
// Carries valid, ready and one result; depends on mcbp_pkg.
interface mcbp_rsp_if;
    import mcbp_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_byte   read_byte;
    logic    reader_open;
    t_fill   fill_count;

    modport source (output valid, status, read_byte, reader_open, fill_count, input ready);
    modport sink   (input valid, status, read_byte, reader_open, fill_count, output ready);
endinterface

// File: sv/mcbp_cfg_if.sv
// Configuration write channel of the multi-channel byte pipe FIFO.
// Carries valid, ready and the capacity value; depends on mcbp_pkg.
interface mcbp_cfg_if;
    import mcbp_pkg::*;

    logic      valid;
    logic      ready;
    t_capacity data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: sv/multi_channel_byte_pipe_fifo.sv
// Top level of the multi-channel byte pipe FIFO: per-pipe pointers and flags
// in flip-flops, the byte slots of all pipes in one shared RAM.
// Depends on mcbp_pkg, the three channel interfaces and mcbp_ram.
//
// Use of the block:
// Each request on i_req names a pipe (1 to NUM_PIPES) and writes a byte, reads
// a byte or marks the end of writing. Every request gives exactly one result on
// o_rsp: a status, the byte read (zero unless a read succeeded), whether the
// pipe's read side is still open and how many bytes the pipe now holds.
// The capacity register is written through i_cfg, which is always ready; it is
// meant to be written only while no request is outstanding.
// Latency and throughput: a write, an end of writing, a refused request or a
// bad pipe id shows its result in the cycle after acceptance, and a new request
// may follow every cycle provided the receiver keeps taking results. A
// successful read first waits in a pending state on the registered read of the
// slot RAM, and i_req is blocked while it waits.
// The single output register holds a result until o_rsp.ready is seen; while
// it is full and not being taken, i_req.ready stays low.
// Reset (synchronous, active low) empties both pipes, opens both sides of each,
// sets the capacity to 64 and drops any pending result. The slot RAM is not
// cleared: slots are written before read unless the capacity was changed.
module multi_channel_byte_pipe_fifo #(
    parameter int NUM_PIPES = 2,
    parameter int DEPTH     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcbp_req_if.sink    i_req,
    mcbp_rsp_if.source  o_rsp,
    mcbp_cfg_if.sink    i_cfg
);
    import mcbp_pkg::*;

    // Widths of the pipe index, slot index, fill count and RAM address.
    localparam int PW   = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CAPW = (CW > 7) ? CW : 7;
    localparam int AW   = $clog2(NUM_PIPES * DEPTH);

    // Per-pipe state.
    logic [IW-1:0] r_head  [NUM_PIPES];
    logic [IW-1:0] r_tail  [NUM_PIPES];
    logic [CW-1:0] r_count [NUM_PIPES];
    logic          r_wopen [NUM_PIPES];
    logic          r_ropen [NUM_PIPES];

    // Capacity register and result stage.
    t_capacity r_capacity;
    logic      r_out_valid;
    logic      r_rd_pend;
    logic      r_use_rd;
    t_status   r_status;
    logic      r_ropen_out;
    t_fill     r_fill;

    logic          accept;
    logic          bad_pipe;
    logic [PW+1:0] pid_m1;
    logic [PW-1:0] pidx;
    logic [CAPW-1:0] cap;
    logic [IW-1:0] cur_head;
    logic [IW-1:0] cur_tail;
    logic [CW-1:0] cur_count;
    logic          cur_wopen;
    logic          cur_ropen;
    logic [CAPW-1:0] head_inc;
    logic [CAPW-1:0] tail_inc;
    logic [IW-1:0] n_head;
    logic [IW-1:0] n_tail;
    logic [CW-1:0] n_count;
    logic          n_wopen;
    logic          n_ropen;
    t_status       n_status;
    logic          do_write;
    logic          do_read;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_byte         ram_rdata;

    // A new request waits while a read is in flight or an untaken result sits
    // in the output register.
    assign i_req.ready = !r_rd_pend && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Capacity clamped to the range 1 to DEPTH.
    always_comb begin
        if (r_capacity == '0) begin
            cap = CAPW'(1);
        end else if (CAPW'(r_capacity) > CAPW'(DEPTH)) begin
            cap = CAPW'(DEPTH);
        end else begin
            cap = CAPW'(r_capacity);
        end
    end

    // Pipe numbers start at one; zero and anything above NUM_PIPES is refused.
    assign bad_pipe = (i_req.pipe_id == '0) || ((PW + 2)'(i_req.pipe_id) > (PW + 2)'(NUM_PIPES));
    assign pid_m1   = (PW + 2)'(i_req.pipe_id) - (PW + 2)'(1);
    assign pidx     = pid_m1[PW-1:0];

    assign cur_head  = r_head[pidx];
    assign cur_tail  = r_tail[pidx];
    assign cur_count = r_count[pidx];
    assign cur_wopen = r_wopen[pidx];
    assign cur_ropen = r_ropen[pidx];

    // Each index steps to the next slot and wraps to zero at the capacity.
    assign head_inc = CAPW'(cur_head) + CAPW'(1);
    assign tail_inc = CAPW'(cur_tail) + CAPW'(1);

    always_comb begin
        n_head   = cur_head;
        n_tail   = cur_tail;
        n_count  = cur_count;
        n_wopen  = cur_wopen;
        n_ropen  = cur_ropen;
        n_status = ST_OK;
        do_write = 1'b0;
        do_read  = 1'b0;
        unique case (i_req.func)
            FUNC_WRITE: begin
                if (!cur_wopen) begin
                    n_status = ST_WR_CLOSED;
                end else if (CAPW'(cur_count) >= cap) begin
                    n_status = ST_FULL;
                end else begin
                    do_write = 1'b1;
                    n_tail   = (tail_inc >= cap) ? '0 : tail_inc[IW-1:0];
                    n_count  = cur_count + CW'(1);
                end
            end
            FUNC_READ: begin
                if (cur_count == '0) begin
                    if (!cur_wopen) begin
                        n_ropen  = 1'b0;
                        n_status = ST_EOS;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end else begin
                    do_read = 1'b1;
                    n_head  = (head_inc >= cap) ? '0 : head_inc[IW-1:0];
                    n_count = cur_count - CW'(1);
                end
            end
            FUNC_END: begin
                if (cur_wopen) begin
                    n_wopen = 1'b0;
                end else begin
                    n_status = ST_WR_CLOSED;
                end
            end
            default: begin
                // The unused code changes nothing and reports the pipe.
            end
        endcase
    end

    // Slots of pipe p occupy addresses p*DEPTH up to p*DEPTH+DEPTH-1.
    assign ram_waddr = AW'(pidx) * AW'(DEPTH) + AW'(cur_tail);
    assign ram_raddr = AW'(pidx) * AW'(DEPTH) + AW'(cur_head);

    mcbp_ram #(
        .WIDTH (8),
        .DEPTH (NUM_PIPES * DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (accept && !bad_pipe && do_write),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.write_byte),
        .i_re    (accept && !bad_pipe && do_read),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Per-pipe state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PIPES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
                r_wopen[i] <= 1'b1;
                r_ropen[i] <= 1'b1;
            end
        end else if (accept && !bad_pipe) begin
            r_head[pidx]  <= n_head;
            r_tail[pidx]  <= n_tail;
            r_count[pidx] <= n_count;
            r_wopen[pidx] <= n_wopen;
            r_ropen[pidx] <= n_ropen;
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_capacity <= i_cfg.data;
        end
    end

    // Result control: a successful read passes through a pending state for the RAM data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else if (accept) begin
            r_rd_pend   <= !bad_pipe && do_read;
            r_out_valid <= bad_pipe || !do_read;
        end else if (r_rd_pend) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, captured at acceptance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (bad_pipe) begin
                r_status    <= ST_BAD_PIPE;
                r_use_rd    <= 1'b0;
                r_ropen_out <= 1'b0;
                r_fill      <= '0;
            end else begin
                r_status    <= n_status;
                r_use_rd    <= do_read;
                r_ropen_out <= n_ropen;
                r_fill      <= t_fill'(n_count);
            end
        end
    end

    // The RAM read register holds its data until the next read, which cannot
    // be issued before this result has been taken.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.read_byte   = r_use_rd ? ram_rdata : '0;
    assign o_rsp.reader_open = r_ropen_out;
    assign o_rsp.fill_count  = r_fill;
endmodule

// File: sv/mcbp_ram.sv
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing.
module mcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_byte_pipe_fifo: random and directed
// requests, bursty sender, stalling receiver, in-order result checking.
// Depends on mcbp_pkg, the three channel interfaces and the block itself.
module testbench;
    import mcbp_pkg::*;

    localparam int NUM_PIPES   = 2;
    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int PLAN        = 0;
    localparam int SCORE       = 1;

    // The package names only three operations; the fourth code must be a no-op.
    localparam t_func FUNC_UNUSED = 2'd3;

    typedef struct packed {
        t_func    func;
        t_pipe_id pipe_id;
        t_byte    write_byte;
    } t_req_item;

    typedef struct packed {
        t_status status;
        t_byte   read_byte;
        logic    reader_open;
        t_fill   fill_count;
    } t_rsp_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Everything the block sees is driven from these, so it is known from time zero.
    logic      req_valid = 1'b0;
    t_req_item req_item  = '0;
    logic      rsp_ready = 1'b0;
    logic      cfg_valid = 1'b0;
    t_capacity cfg_data  = CAPACITY_RESET;

    mcbp_req_if req_if ();
    mcbp_rsp_if rsp_if ();
    mcbp_cfg_if cfg_if ();

    assign req_if.valid      = req_valid;
    assign req_if.func       = req_item.func;
    assign req_if.pipe_id    = req_item.pipe_id;
    assign req_if.write_byte = req_item.write_byte;
    assign rsp_if.ready      = rsp_ready;
    assign cfg_if.valid      = cfg_valid;
    assign cfg_if.data       = cfg_data;

    multi_channel_byte_pipe_fifo #(
        .NUM_PIPES (NUM_PIPES),
        .DEPTH     (DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Two copies of the pipe state. The PLAN copy runs ahead as requests are
    // generated, so that the generator knows what each pipe holds; the SCORE
    // copy advances only when the block accepts a request and yields the
    // expected results. Flags are stored inverted so that zero is the reset state.
    t_byte slot_mem     [2][NUM_PIPES][DEPTH];
    bit    slot_written [2][NUM_PIPES][DEPTH];
    int    rd_ptr       [2][NUM_PIPES];
    int    wr_ptr       [2][NUM_PIPES];
    int    fill_level   [2][NUM_PIPES];
    bit    writer_done  [2][NUM_PIPES];
    bit    reader_shut  [2][NUM_PIPES];
    int    capacity_reg [2] = '{CAPACITY_RESET, CAPACITY_RESET};

    t_req_item pending_reqs[$];
    t_rsp_item pending_results[$];
    int        fault_count  = 0;
    int        quiet_cycles = 0;

    int        burst_left = 1;
    int        gap_left   = 0;
    logic [15:0] ready_mask = 16'hffff;
    int        mask_age   = 0;
    int        mask_pos   = 0;

    // Applies one request to the chosen copy of the pipe state and returns
    // the result that the block must give for it.
    function automatic t_rsp_item pipe_step(input int m, input t_req_item r);
        t_rsp_item res;
        int        p;
        int        cap;
        res = '0;
        res.status = ST_OK;
        cap = capacity_reg[m];
        if (cap < 1) cap = 1;
        if (cap > DEPTH) cap = DEPTH;
        if (r.pipe_id < 1 || r.pipe_id > NUM_PIPES) begin
            res.status = ST_BAD_PIPE;
            return res;
        end
        p = r.pipe_id - 1;
        case (r.func)
            FUNC_WRITE: begin
                if (writer_done[m][p]) begin
                    res.status = ST_WR_CLOSED;
                end else if (fill_level[m][p] >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    slot_mem[m][p][wr_ptr[m][p]]     = r.write_byte;
                    slot_written[m][p][wr_ptr[m][p]] = 1'b1;
                    wr_ptr[m][p] = (wr_ptr[m][p] + 1 >= cap) ? 0 : wr_ptr[m][p] + 1;
                    fill_level[m][p]++;
                end
            end
            FUNC_READ: begin
                if (fill_level[m][p] == 0) begin
                    if (writer_done[m][p]) begin
                        reader_shut[m][p] = 1'b1;
                        res.status = ST_EOS;
                    end else begin
                        res.status = ST_EMPTY;
                    end
                end else begin
                    res.read_byte = slot_mem[m][p][rd_ptr[m][p]];
                    rd_ptr[m][p] = (rd_ptr[m][p] + 1 >= cap) ? 0 : rd_ptr[m][p] + 1;
                    fill_level[m][p]--;
                end
            end
            FUNC_END: begin
                if (writer_done[m][p]) res.status = ST_WR_CLOSED;
                else writer_done[m][p] = 1'b1;
            end
            default: ;
        endcase
        res.reader_open = !reader_shut[m][p];
        res.fill_count  = t_fill'(fill_level[m][p]);
        return res;
    endfunction

    // Sender: bursts of random length separated by random gaps. A new request
    // is only presented once the previous one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_if.ready) begin
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_valid <= 1'b1;
                req_item  <= pending_reqs.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a 16-bit mask that is replaced now and then.
    // One mode never stalls; two always leave some ready cycles, one nearly always.
    always @(posedge i_clk) begin
        if (mask_age == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_mask = 16'hffff;
                1:       ready_mask = 16'($urandom) | 16'h0101;
                2:       ready_mask = ~(16'($urandom) & 16'($urandom));
                default: ready_mask = 16'($urandom) | 16'h0001;
            endcase
            mask_age = $urandom_range(16, 128);
        end
        mask_age--;
        mask_pos = (mask_pos + 1) % 16;
        rsp_ready <= ready_mask[mask_pos];
    end

    // Scoreboard: checks each taken result against the oldest expectation,
    // then predicts the result of any request accepted at this edge.
    always @(posedge i_clk) begin
        t_rsp_item got;
        t_rsp_item want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_ready) begin
                got.status      = rsp_if.status;
                got.read_byte   = rsp_if.read_byte;
                got.reader_open = rsp_if.reader_open;
                got.fill_count  = rsp_if.fill_count;
                if (pending_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: result with nothing outstanding: status %0d byte %02h",
                                 $realtime, got.status, got.read_byte);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.read_byte !== want.read_byte ||
                        got.reader_open !== want.reader_open ||
                        got.fill_count !== want.fill_count) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("%0t: mismatch, expected status %0d byte %02h open %0b fill %0d",
                                     $realtime, want.status, want.read_byte,
                                     want.reader_open, want.fill_count);
                            $display("%0t: mismatch, got status %0d byte %02h open %0b fill %0d",
                                     $realtime, got.status, got.read_byte,
                                     got.reader_open, got.fill_count);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_if.ready)
                capacity_reg[SCORE] = cfg_data;
            if (req_valid && req_if.ready)
                pending_results.push_back(pipe_step(SCORE, req_item));
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready) ||
            (cfg_valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Blocks until every queued request has gone in and every result has come
    // back, then waits on before returning so the block is truly idle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_valid || pending_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input t_capacity value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_valid <= 1'b0;
        capacity_reg[PLAN] = value;
    endtask

    // Queues one request. After a capacity change the head of a pipe may land
    // on a slot that has never held data; such a read is turned into a write.
    task automatic queue_request(input t_func f, input t_pipe_id id, input t_byte b);
        t_req_item r;
        int        p;
        r.func       = f;
        r.pipe_id    = id;
        r.write_byte = b;
        if (f == FUNC_READ && id >= 1 && id <= NUM_PIPES) begin
            p = id - 1;
            if (fill_level[PLAN][p] > 0 && !slot_written[PLAN][p][rd_ptr[PLAN][p]])
                r.func = FUNC_WRITE;
        end
        void'(pipe_step(PLAN, r));
        pending_reqs.push_back(r);
    endtask

    // Random traffic in runs with a write-heavy, balanced or read-heavy mix so
    // that pipes reach both full and empty. A little noise goes in throughout:
    // bad pipe ids and the unused operation. Half-way through, the sender
    // holds off until every result has been returned.
    task automatic random_traffic(input int n, input int end_pct);
        int       i;
        int       wr_pct;
        int       run_left;
        int       roll;
        t_pipe_id id;
        t_func    f;
        wr_pct   = 50;
        run_left = 0;
        for (i = 0; i < n; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(8, 32);
                case ($urandom_range(0, 2))
                    0:       wr_pct = 15;
                    1:       wr_pct = 50;
                    default: wr_pct = 85;
                endcase
            end
            run_left--;
            if (i == n / 2) wait_idle();
            roll = $urandom_range(0, 99);
            id   = t_pipe_id'($urandom_range(1, NUM_PIPES));
            if (roll < 4) begin
                id = ($urandom_range(0, 1) == 0) ? t_pipe_id'(0) : t_pipe_id'(NUM_PIPES + 1);
                f  = t_func'($urandom_range(0, 3));
            end else if (roll < 8) begin
                f = FUNC_UNUSED;
            end else if (roll < 8 + end_pct) begin
                f = FUNC_END;
            end else if ($urandom_range(0, 99) < wr_pct) begin
                f = FUNC_WRITE;
            end else begin
                f = FUNC_READ;
            end
            queue_request(f, id, t_byte'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        t_capacity phase_caps [10];
        int        k;
        phase_caps = '{7'd127, 7'd1, 7'd64, 7'd3, 7'd0, 7'd17, 7'd64, 7'd8, 7'd33, 7'd50};
        phase_caps[9] = t_capacity'($urandom_range(0, 127));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed start at the reset capacity: bad pipe ids with every
        // operation, reads of empty open pipes, extreme bytes, the no-op code.
        queue_request(FUNC_WRITE,  t_pipe_id'(0), 8'hA5);
        queue_request(FUNC_READ,   t_pipe_id'(3), 8'h00);
        queue_request(FUNC_END,    t_pipe_id'(0), 8'hFF);
        queue_request(FUNC_UNUSED, t_pipe_id'(3), 8'h00);
        queue_request(FUNC_READ,   t_pipe_id'(1), 8'h00);
        queue_request(FUNC_READ,   t_pipe_id'(2), 8'h00);
        queue_request(FUNC_WRITE,  t_pipe_id'(1), 8'h00);
        queue_request(FUNC_WRITE,  t_pipe_id'(1), 8'hFF);
        queue_request(FUNC_WRITE,  t_pipe_id'(2), 8'h5A);
        queue_request(FUNC_UNUSED, t_pipe_id'(2), 8'hFF);
        queue_request(FUNC_READ,   t_pipe_id'(1), 8'h00);
        queue_request(FUNC_READ,   t_pipe_id'(1), 8'h00);
        queue_request(FUNC_READ,   t_pipe_id'(2), 8'h00);

        // Small capacity: fill to the limit, then shrink the capacity below
        // what is held, which must refuse writes yet let reads drain.
        write_capacity(7'd2);
        queue_request(FUNC_WRITE, t_pipe_id'(1), 8'h11);
        queue_request(FUNC_WRITE, t_pipe_id'(1), 8'h22);
        queue_request(FUNC_WRITE, t_pipe_id'(1), 8'h33);
        write_capacity(7'd0);
        queue_request(FUNC_WRITE, t_pipe_id'(1), 8'h44);
        queue_request(FUNC_READ,  t_pipe_id'(1), 8'h00);
        queue_request(FUNC_READ,  t_pipe_id'(1), 8'h00);
        queue_request(FUNC_READ,  t_pipe_id'(1), 8'h00);

        // Random phases at a spread of capacities, both extremes included.
        // Ending writes is permanent, so it is kept for closing pipe 2 and the last phase.
        for (k = 0; k < 10; k++) begin
            write_capacity(phase_caps[k]);
            random_traffic(125, 0);
        end

        // Closing pipe 2: drain it, write a little, end writing, then check
        // refused writes, a second end, reads after the end and end of stream.
        write_capacity(7'd4);
        for (k = 0; k < 70 && fill_level[PLAN][1] > 0; k++)
            queue_request(FUNC_READ, t_pipe_id'(2), 8'h00);
        queue_request(FUNC_WRITE, t_pipe_id'(2), 8'h81);
        queue_request(FUNC_WRITE, t_pipe_id'(2), 8'h7E);
        queue_request(FUNC_END,   t_pipe_id'(2), 8'h00);
        queue_request(FUNC_WRITE, t_pipe_id'(2), 8'hC3);
        queue_request(FUNC_END,   t_pipe_id'(2), 8'h00);
        for (k = 0; k < 4; k++)
            queue_request(FUNC_READ, t_pipe_id'(2), 8'h00);

        // Last phase lets ends through on both pipes.
        random_traffic(200, 3);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
sv/mcbp_pkg.sv
sv/mcbp_req_if.sv
sv/mcbp_rsp_if.sv
sv/mcbp_cfg_if.sv
sv/mcbp_ram.sv
sv/multi_channel_byte_pipe_fifo.sv
verif/testbench.sv
